/* src/grbf_pkg.sv */
// ----------------------------------------------------------------------------
// grbf_pkg
// Shared types, widths and the 2^-x table of the Gaussian RBF kernel.
// ----------------------------------------------------------------------------
package grbf_pkg;

	localparam int MAX_DIMS   = 3;
	localparam int COORD_W    = 16;
	localparam int MAG_W      = 16;
	localparam int SQ_W       = 32;
	localparam int D2_W       = 34;
	localparam int SHAPE_W    = 16;
	localparam int S2_W       = 32;
	localparam int LO_W       = 64;
	localparam int T_W        = 66;
	localparam int U_W        = 20;
	localparam int XP_W       = 37;
	localparam int X_W        = 21;
	localparam int K_W        = 5;
	localparam int KV_W       = 16;
	localparam int DIMS_W     = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	localparam logic [SHAPE_W-1:0] SHAPE_RESET = 16'd4096;
	localparam logic [DIMS_W-1:0]  DIMS_RESET  = 2'd3;
	localparam logic [XP_W-1:0]    LOG2E_Q16   = 37'd94548;
	localparam logic [KV_W-1:0]    KV_ONE      = 16'd32768;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SHAPE = 1'b0,
		REG_DIMS  = 1'b1
	} cfg_reg_t;

	// absolute coordinate differences, zero for unused coordinates
	typedef struct packed {
		logic [MAX_DIMS-1:0][MAG_W-1:0] mag;
	} pair_t;

	typedef struct packed {
		logic                  full;
		logic                  empty;
		logic [FIFO_CNT_W-1:0] count;
	} q_stat_t;

	// round(32768 * 2^(-i/64)), with 2^-1 appended for the last interval
	localparam logic [KV_W-1:0] POW2_TAB [65] = '{
		16'd32768, 16'd32415, 16'd32066, 16'd31720, 16'd31379, 16'd31041, 16'd30706, 16'd30376,
		16'd30048, 16'd29725, 16'd29405, 16'd29088, 16'd28774, 16'd28464, 16'd28158, 16'd27855,
		16'd27554, 16'd27258, 16'd26964, 16'd26674, 16'd26386, 16'd26102, 16'd25821, 16'd25543,
		16'd25268, 16'd24995, 16'd24726, 16'd24460, 16'd24196, 16'd23936, 16'd23678, 16'd23423,
		16'd23170, 16'd22921, 16'd22674, 16'd22430, 16'd22188, 16'd21949, 16'd21713, 16'd21479,
		16'd21247, 16'd21019, 16'd20792, 16'd20568, 16'd20347, 16'd20127, 16'd19911, 16'd19696,
		16'd19484, 16'd19274, 16'd19066, 16'd18861, 16'd18658, 16'd18457, 16'd18258, 16'd18061,
		16'd17867, 16'd17674, 16'd17484, 16'd17296, 16'd17109, 16'd16925, 16'd16743, 16'd16562,
		16'd16384
	};

endpackage

/* src/grbf_if.sv */
// ----------------------------------------------------------------------------
// grbf_if
// Valid/ready channels of the Gaussian RBF kernel: point pairs in, values out.
// ----------------------------------------------------------------------------
interface grbf_pair_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] p_x;
	logic signed [15:0] p_y;
	logic signed [15:0] p_z;
	logic signed [15:0] q_x;
	logic signed [15:0] q_y;
	logic signed [15:0] q_z;

	modport source (output valid, p_x, p_y, p_z, q_x, q_y, q_z, input ready);
	modport sink   (input valid, p_x, p_y, p_z, q_x, q_y, q_z, output ready);
endinterface

interface grbf_kern_if;
	logic        valid;
	logic        ready;
	logic [15:0] kernel_value;

	modport source (output valid, kernel_value, input ready);
	modport sink   (input valid, kernel_value, output ready);
endinterface

/* src/grbf_front.sv */
// ----------------------------------------------------------------------------
// grbf_front
// Accepts point pairs, masks unused coordinates and forms |p - q| per lane.
// ----------------------------------------------------------------------------
module grbf_front (
	input  logic                        clk,
	input  logic                        arst_n,
	grbf_pair_if.sink                   pair,
	input  logic [grbf_pkg::DIMS_W-1:0] dims,
	input  logic                        q_full,
	output logic                        q_push,
	output grbf_pkg::pair_t             q_data
);

	logic                                 vld_s1;
	grbf_pkg::pair_t                      data_s1;
	grbf_pkg::pair_t                      mag_c;
	logic signed [grbf_pkg::COORD_W-1:0]  pc [grbf_pkg::MAX_DIMS];
	logic signed [grbf_pkg::COORD_W-1:0]  qc [grbf_pkg::MAX_DIMS];
	logic signed [grbf_pkg::COORD_W:0]    dif [grbf_pkg::MAX_DIMS];
	logic signed [grbf_pkg::COORD_W:0]    neg [grbf_pkg::MAX_DIMS];

	assign pc[0] = pair.p_x;
	assign pc[1] = pair.p_y;
	assign pc[2] = pair.p_z;
	assign qc[0] = pair.q_x;
	assign qc[1] = pair.q_y;
	assign qc[2] = pair.q_z;

	always_comb begin
		for (int c = 0; c < grbf_pkg::MAX_DIMS; c++) begin
			dif[c] = {pc[c][grbf_pkg::COORD_W-1], pc[c]} - {qc[c][grbf_pkg::COORD_W-1], qc[c]};
			neg[c] = -dif[c];
			if (dims > grbf_pkg::DIMS_W'(c)) begin
				mag_c.mag[c] = dif[c][grbf_pkg::COORD_W] ? neg[c][grbf_pkg::MAG_W-1:0]
					: dif[c][grbf_pkg::MAG_W-1:0];
			end else begin
				mag_c.mag[c] = '0;
			end
		end
	end

	// hold the stage while the queue is full
	assign pair.ready = !vld_s1 || !q_full;
	assign q_push     = vld_s1 && !q_full;
	assign q_data     = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (pair.ready) begin
			vld_s1 <= pair.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pair.valid && pair.ready) begin
			data_s1 <= mag_c;
		end
	end

endmodule

/* src/grbf_fifo.sv */
// ----------------------------------------------------------------------------
// grbf_fifo
// Short queue that decouples the front end from the arithmetic pipeline.
// ----------------------------------------------------------------------------
module grbf_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  grbf_pkg::pair_t   wdata,
	input  logic              pop,
	output grbf_pkg::pair_t   rdata,
	output grbf_pkg::q_stat_t stat
);

	grbf_pkg::pair_t                 mem [grbf_pkg::FIFO_DEPTH];
	logic [grbf_pkg::FIFO_PTR_W-1:0] wr_q;
	logic [grbf_pkg::FIFO_PTR_W-1:0] rd_q;
	logic [grbf_pkg::FIFO_CNT_W-1:0] cnt_q;

	assign rdata      = mem[rd_q];
	assign stat.count = cnt_q;
	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == grbf_pkg::FIFO_CNT_W'(grbf_pkg::FIFO_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* src/grbf_back.sv */
// ----------------------------------------------------------------------------
// grbf_back
// Arithmetic pipeline: squared distance, exponent, table lookup and scaling.
// ----------------------------------------------------------------------------
module grbf_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_empty,
	input  grbf_pkg::pair_t              q_data,
	output logic                         q_pop,
	input  logic [grbf_pkg::SHAPE_W-1:0] shape,
	grbf_kern_if.source                  kern
);

	logic en;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, out_vld_q;

	logic [grbf_pkg::SQ_W-1:0]  sq_s1 [grbf_pkg::MAX_DIMS];
	logic [grbf_pkg::S2_W-1:0]  sh2_s1;
	logic [grbf_pkg::D2_W-1:0]  d2_s2;
	logic [grbf_pkg::S2_W-1:0]  sh2_s2;
	logic [grbf_pkg::LO_W-1:0]  lo_s3;
	logic [grbf_pkg::D2_W-1:0]  hi_s3;
	logic                       big_s4, big_s5, big_s6;
	logic [grbf_pkg::U_W-1:0]   u_s4;
	logic [grbf_pkg::X_W-1:0]   x_s5;
	logic [grbf_pkg::K_W-1:0]   k_s6;
	logic [grbf_pkg::KV_W-1:0]  v_s6;
	logic [grbf_pkg::KV_W-1:0]  out_val_q;

	logic [grbf_pkg::D2_W-1:0]  d2_c;
	logic [grbf_pkg::T_W-1:0]   t_c;
	logic [grbf_pkg::XP_W-1:0]  xp_c;
	logic [5:0]                 idx_c;
	logic [9:0]                 w_c;
	logic [grbf_pkg::KV_W-1:0]  a_c;
	logic [grbf_pkg::KV_W-1:0]  b_c;
	logic [grbf_pkg::KV_W-1:0]  ab_full_c;
	logic [8:0]                 ab_c;
	logic [18:0]                wp_c;
	logic [19:0]                rp_c;
	logic [grbf_pkg::KV_W-1:0]  v_c;
	logic [23:0]                rnd_c;
	logic [23:0]                sh_c;
	logic [grbf_pkg::KV_W-1:0]  res_c;

	// advance the whole pipeline whenever the output register can take an item
	assign en    = !out_vld_q || kern.ready;
	assign q_pop = en && !q_empty;

	always_comb begin
		d2_c = '0;
		for (int c = 0; c < grbf_pkg::MAX_DIMS; c++) begin
			d2_c = d2_c + grbf_pkg::D2_W'(sq_s1[c]);
		end
	end

	assign t_c  = {hi_s3, 32'b0} + {2'b0, lo_s3};
	assign xp_c = grbf_pkg::XP_W'(u_s4) * grbf_pkg::LOG2E_Q16;

	// linear interpolation between neighboring table entries
	assign idx_c     = x_s5[15:10];
	assign w_c       = x_s5[9:0];
	assign a_c       = grbf_pkg::POW2_TAB[{1'b0, idx_c}];
	assign b_c       = grbf_pkg::POW2_TAB[{1'b0, idx_c} + 7'd1];
	assign ab_full_c = a_c - b_c;
	assign ab_c      = ab_full_c[8:0];
	assign wp_c      = 19'(ab_c) * 19'(w_c);
	assign rp_c      = {1'b0, wp_c} + 20'd512;
	assign v_c       = a_c - grbf_pkg::KV_W'(rp_c[19:10]);

	// scale by 2^-k with round half up
	assign rnd_c = 24'd1 << (k_s6 - 5'd1);
	assign sh_c  = ({8'b0, v_s6} + rnd_c) >> k_s6;

	always_comb begin
		if (big_s6) begin
			res_c = '0;
		end else if (k_s6 == '0) begin
			res_c = v_s6;
		end else begin
			res_c = sh_c[grbf_pkg::KV_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1    <= !q_empty;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			vld_s6    <= vld_s5;
			out_vld_q <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < grbf_pkg::MAX_DIMS; c++) begin
				sq_s1[c] <= grbf_pkg::SQ_W'(q_data.mag[c]) * grbf_pkg::SQ_W'(q_data.mag[c]);
			end
			sh2_s1    <= grbf_pkg::S2_W'(shape) * grbf_pkg::S2_W'(shape);
			d2_s2     <= d2_c;
			sh2_s2    <= sh2_s1;
			lo_s3     <= grbf_pkg::LO_W'(sh2_s2) * grbf_pkg::LO_W'(d2_s2[31:0]);
			hi_s3     <= grbf_pkg::D2_W'(sh2_s2) * grbf_pkg::D2_W'(d2_s2[33:32]);
			big_s4    <= |t_c[grbf_pkg::T_W-1:44];
			u_s4      <= t_c[43:24];
			big_s5    <= big_s4;
			x_s5      <= xp_c[36:16];
			big_s6    <= big_s5;
			k_s6      <= x_s5[20:16];
			v_s6      <= v_c;
			out_val_q <= res_c;
		end
	end

	assign kern.valid        = out_vld_q;
	assign kern.kernel_value = out_val_q;

endmodule

/* src/gaussian_rbf_kernel.sv */
// ----------------------------------------------------------------------------
// gaussian_rbf_kernel
// Gaussian RBF kernel exp(-(shape * |p - q|)^2) of two 3-D points, Q1.15 out.
//
// Channels: pair carries one point pair (signed Q8.8 coordinates) per item,
// kern carries one kernel value (unsigned Q1.15, 32768 = 1.0) per item, both
// valid/ready. The write port sets shape (index 0, Q4.12) and dims
// (index 1); write it only while no item is in flight.
// Throughput: one item per cycle while kern is ready. From accept on pair to
// valid on kern, an item passes the front register, the 4-entry queue and the six
// arithmetic stages ahead of the output register.
// Reset: clears the queue and all valid bits; shape returns to 1.0 and dims
// to 3. No clearing pass is needed, items are taken right after reset.
// Stall: when kern is held, the arithmetic pipeline freezes, the queue fills
// and pair drops ready once the queue and the front register are full.
// ----------------------------------------------------------------------------
module gaussian_rbf_kernel (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [grbf_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [grbf_pkg::CFG_DATA_W-1:0] cfg_wdata,
	grbf_pair_if.sink                       pair,
	grbf_kern_if.source                     kern
);

	logic [grbf_pkg::SHAPE_W-1:0] shape_q;
	logic [grbf_pkg::DIMS_W-1:0]  dims_q;
	logic                         q_push;
	logic                         q_pop;
	grbf_pkg::pair_t              q_wdata;
	grbf_pkg::pair_t              q_rdata;
	grbf_pkg::q_stat_t            q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q <= grbf_pkg::SHAPE_RESET;
			dims_q  <= grbf_pkg::DIMS_RESET;
		end else if (cfg_we) begin
			case (grbf_pkg::cfg_reg_t'(cfg_idx))
				grbf_pkg::REG_SHAPE: shape_q <= cfg_wdata[grbf_pkg::SHAPE_W-1:0];
				grbf_pkg::REG_DIMS:  dims_q  <= cfg_wdata[grbf_pkg::DIMS_W-1:0];
				default: ;
			endcase
		end
	end

	grbf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pair   (pair),
		.dims   (dims_q),
		.q_full (q_stat.full),
		.q_push (q_push),
		.q_data (q_wdata)
	);

	grbf_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	grbf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_stat.empty),
		.q_data  (q_rdata),
		.q_pop   (q_pop),
		.shape   (shape_q),
		.kern    (kern)
	);

`ifndef NO_ASSERTIONS
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.count <= grbf_pkg::FIFO_CNT_W'(grbf_pkg::FIFO_DEPTH))
		else $error("queue count beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("push into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("pop from an empty queue");

	a_kv_range: assert property (@(posedge clk) disable iff (!arst_n)
		kern.valid |-> kern.kernel_value <= grbf_pkg::KV_ONE)
		else $error("kernel value above 1.0");
`endif

endmodule
